@@ hdl/plsp_pkg.sv @@
package plsp_pkg;

  localparam int unsigned NUM_KW   = 6;
  localparam int unsigned KW_CHARS = 16;
  localparam int unsigned KW_W     = KW_CHARS * 8;
  localparam logic [15:0] MAX_PORT = 16'hFFFF;
  localparam logic [3:0]  LEN_SAT  = 4'd15;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // keyword list, index doubles as the service code (index 0 is "all")
  localparam logic [KW_W-1:0] KW_TEXT [NUM_KW] = '{
    KW_W'("all"), KW_W'("ssh"), KW_W'("no-auth-ssh"),
    KW_W'("files"), KW_W'("exec"), KW_W'("exit-node")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd3, 4'd3, 4'd11, 4'd5, 4'd4, 4'd9};
  localparam int unsigned KW_ALL = 0;

  typedef enum logic [0:0] {CMD_CHAR = 1'b0, CMD_END = 1'b1} cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_RANGE       = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SVC_NONE      = 3'd0,
    SVC_SSH       = 3'd1,
    SVC_NOAUTHSSH = 3'd2,
    SVC_FILES     = 3'd3,
    SVC_EXEC      = 3'd4,
    SVC_EXITNODE  = 3'd5
  } service_t;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_INVALID = 2'd1,
    FLT_OVER    = 2'd2
  } fault_t;

  typedef struct packed {
    fault_t      fault;
    logic [15:0] val;
  } bound_t;

  // one decimal digit into a bound; first fault sticks
  function automatic bound_t feed_bound(bound_t b, logic [7:0] c);
    bound_t      r;
    logic [19:0] v;
    r = b;
    v = ({4'b0, b.val} << 3) + ({4'b0, b.val} << 1) + {16'b0, c[3:0]};
    if (b.fault == FLT_NONE) begin
      if (c < CH_ZERO || c > CH_NINE) begin
        r.fault = FLT_INVALID;
      end else if (v > {4'b0, MAX_PORT}) begin
        r.fault = FLT_OVER;
      end else begin
        r.val = v[15:0];
      end
    end
    return r;
  endfunction

  function automatic status_t bound_status(bound_t b);
    status_t s;
    case (b.fault)
      FLT_INVALID: s = ST_INVALID;
      FLT_OVER:    s = ST_RANGE;
      default:     s = (b.val == 16'd0) ? ST_INVALID : ST_OK;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] len_inc(logic [3:0] n);
    return (n < LEN_SAT) ? n + 4'd1 : n;
  endfunction

endpackage

@@ hdl/port_list_spec_parser.sv @@
// Port-list spec parser.
// Input channel (in_valid/in_ready): one word per spec character (cmd = 0,
// byte in ch) or an end word (cmd = 1). Output channel (out_valid/out_ready):
// one result word per finished entry: a port range (range_valid = 1) or the
// final status. Entries close at a comma or at the end word; the first error
// gives a final word with done_res = 1 and later characters are dropped up to
// the next end word, which gives no result and rearms the parser.
// A word waits in the input register and is parsed from there into the
// result register, whose word is shown on out_valid.
// Throughput: one word per cycle while the receiver does not stall; the
// parse is a single pass of short logic (keyword compare, times-ten
// accumulate on 16 bits, range swap).
// Reset (rst, synchronous): both registers empty, parser at start of a spec.
// Receiver stall: the result register holds its word; the input register
// still takes one more word, after which in_ready drops until out_ready.
module port_list_spec_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [7:0]           ch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 range_valid,
  output logic [15:0]          range_lo,
  output logic [15:0]          range_hi,
  output logic                 done_res,
  output plsp_pkg::status_t    status,
  output plsp_pkg::service_t   service
);
  import plsp_pkg::*;

  // input register
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_ch;

  // parser state
  logic                entry_phase, entry_phase_next;
  logic                pending_blank, pending_blank_next;
  logic [NUM_KW-1:0]   keyword_candidates, keyword_candidates_next;
  logic [3:0]          body_length, body_length_next;
  logic                in_upper_bound, in_upper_bound_next;
  bound_t              lower_bnd, lower_bnd_next;
  bound_t              upper_bnd, upper_bnd_next;
  logic                spec_failed, spec_failed_next;

  // entry verdict
  logic                hit_found;
  logic [2:0]          hit_idx;
  status_t             fin_status;
  logic [15:0]         fin_lo, fin_hi;
  service_t            fin_svc;

  logic                adv;
  logic                res_fire;
  logic                res_done;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd <= cmd;
      s1_ch  <= ch;
    end
  end

  // judge the open entry: keyword first, then lower bound, then upper
  always_comb begin
    logic [15:0] a, b;
    hit_found = 1'b0;
    hit_idx   = 3'd0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (!hit_found && keyword_candidates[i] && body_length == KW_LEN[i]) begin
        hit_found = 1'b1;
        hit_idx   = 3'(i);
      end
    end
    a = lower_bnd.val;
    b = in_upper_bound ? upper_bnd.val : lower_bnd.val;
    fin_lo  = 16'd0;
    fin_hi  = 16'd0;
    fin_svc = SVC_NONE;
    if (body_length == 4'd0) begin
      fin_status = ST_INVALID;
    end else if (hit_found && hit_idx == 3'(KW_ALL)) begin
      fin_status = ST_OK;
      fin_lo     = 16'd1;
      fin_hi     = MAX_PORT;
    end else if (hit_found) begin
      fin_status = ST_UNSUPPORTED;
      fin_svc    = service_t'(hit_idx);
    end else begin
      fin_status = bound_status(lower_bnd);
      if (fin_status == ST_OK && in_upper_bound) begin
        fin_status = bound_status(upper_bnd);
      end
      if (fin_status == ST_OK) begin
        fin_lo = (a > b) ? b : a;
        fin_hi = (a > b) ? a : b;
      end
    end
  end

  // next state for the word in the input register
  always_comb begin
    bound_t            bsel;
    logic [NUM_KW-1:0] cand;
    logic [3:0]        blen;
    logic [3:0]        ofs;
    entry_phase_next        = entry_phase;
    pending_blank_next      = pending_blank;
    keyword_candidates_next = keyword_candidates;
    body_length_next        = body_length;
    in_upper_bound_next     = in_upper_bound;
    lower_bnd_next          = lower_bnd;
    upper_bnd_next          = upper_bnd;
    spec_failed_next        = spec_failed;
    res_fire                = 1'b0;
    res_done                = 1'b0;
    bsel                    = in_upper_bound ? upper_bnd : lower_bnd;
    cand                    = keyword_candidates;
    blen                    = body_length;
    ofs                     = 4'd0;

    if (s1_valid && adv) begin
      if (s1_cmd == CMD_END) begin
        res_fire = !spec_failed;
        res_done = 1'b1;
        entry_phase_next        = 1'b0;
        pending_blank_next      = 1'b0;
        keyword_candidates_next = '1;
        body_length_next        = 4'd0;
        in_upper_bound_next     = 1'b0;
        lower_bnd_next          = '{FLT_NONE, 16'd0};
        upper_bnd_next          = '{FLT_NONE, 16'd0};
        spec_failed_next        = 1'b0;
      end else if (!spec_failed) begin
        if (s1_ch == CH_COMMA) begin
          res_fire = 1'b1;
          res_done = (fin_status != ST_OK);
          entry_phase_next        = 1'b0;
          pending_blank_next      = 1'b0;
          keyword_candidates_next = '1;
          body_length_next        = 4'd0;
          in_upper_bound_next     = 1'b0;
          lower_bnd_next          = '{FLT_NONE, 16'd0};
          upper_bnd_next          = '{FLT_NONE, 16'd0};
          spec_failed_next        = (fin_status != ST_OK);
        end else if (s1_ch == CH_SPACE || s1_ch == CH_TAB) begin
          if (entry_phase) begin
            pending_blank_next = 1'b1;
          end
        end else begin
          entry_phase_next = 1'b1;
          // blanks inside the body: a bad character, kills every keyword
          if (pending_blank) begin
            bsel = feed_bound(bsel, CH_SPACE);
            cand = '0;
            blen = len_inc(blen);
          end
          pending_blank_next = 1'b0;
          for (int i = 0; i < NUM_KW; i++) begin
            ofs = KW_LEN[i] - 4'd1 - blen;
            if (blen >= KW_LEN[i] || KW_TEXT[i][8*ofs +: 8] != s1_ch) begin
              cand[i] = 1'b0;
            end
          end
          if (s1_ch == CH_DASH && blen != 4'd0 && !in_upper_bound) begin
            in_upper_bound_next = 1'b1;
          end else begin
            bsel = feed_bound(bsel, s1_ch);
          end
          if (in_upper_bound) begin
            upper_bnd_next = bsel;
          end else begin
            lower_bnd_next = bsel;
          end
          keyword_candidates_next = cand;
          body_length_next        = len_inc(blen);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_phase        <= 1'b0;
      pending_blank      <= 1'b0;
      keyword_candidates <= '1;
      body_length        <= 4'd0;
      in_upper_bound     <= 1'b0;
      lower_bnd          <= '{FLT_NONE, 16'd0};
      upper_bnd          <= '{FLT_NONE, 16'd0};
      spec_failed        <= 1'b0;
    end else begin
      entry_phase        <= entry_phase_next;
      pending_blank      <= pending_blank_next;
      keyword_candidates <= keyword_candidates_next;
      body_length        <= body_length_next;
      in_upper_bound     <= in_upper_bound_next;
      lower_bnd          <= lower_bnd_next;
      upper_bnd          <= upper_bnd_next;
      spec_failed        <= spec_failed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      range_valid <= (fin_status == ST_OK);
      range_lo    <= fin_lo;
      range_hi    <= fin_hi;
      done_res    <= res_done || (fin_status != ST_OK);
      status      <= fin_status;
      service     <= fin_svc;
    end
  end

  // a range word always carries a non-empty, ordered range
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_valid |-> range_lo != 16'd0 && range_lo <= range_hi)
    else $error("range word with bad bounds");

  // an error word always closes the spec
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> done_res && !range_valid)
    else $error("error word not final");

  // service is named only for the unsupported status
  a_svc: assert property (@(posedge clk) disable iff (rst)
    out_valid && service != SVC_NONE |-> status == ST_UNSUPPORTED)
    else $error("service without unsupported status");

  // a failed spec stays failed until an end word is parsed
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    spec_failed && !(s1_valid && adv && s1_cmd == CMD_END) |=> spec_failed)
    else $error("failed spec rearmed without end word");

endmodule

@@ tb/tb_port_list_spec_parser.sv @@
`timescale 1ns / 100ps

module tb_port_list_spec_parser;
  import plsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned STREAM_WORDS = 1800;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned REPORT_MAX   = 10;

  // one input word: a spec character or the end marker
  typedef struct {
    cmd_t       op;
    logic [7:0] c;
  } spec_word_t;

  // one result word as the parser should present it
  typedef struct {
    logic        rng;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        done;
    status_t     st;
    service_t    svc;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        range_valid;
  logic [15:0] range_lo;
  logic [15:0] range_hi;
  logic        done_res;
  status_t     status;
  service_t    service;

  port_list_spec_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .range_valid (range_valid),
    .range_lo    (range_lo),
    .range_hi    (range_hi),
    .done_res    (done_res),
    .status      (status),
    .service     (service)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser state as the testbench tracks it
  // ---------------------------------------------------------------------
  logic        ent_open;    // first non-blank of the entry seen
  logic        blank_held;  // blank after the body began, not yet judged
  logic [5:0]  kw_live;     // keywords still matching, bit index = keyword
  logic [3:0]  body_len;    // untrimmed length, saturating
  logic        on_upper;    // dash seen, digits go to the upper bound
  int unsigned lo_acc;
  int unsigned hi_acc;
  fault_t      lo_flt;
  fault_t      hi_flt;
  logic        spec_dead;   // error given, swallow until the end word

  spec_word_t   spec_stream[$];    // words still to be driven
  port_result_t spec_verdicts[$];  // results owed by the parser, oldest first

  spec_word_t  next_word;
  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned bad_words = 0;
  int unsigned cycles = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        src_calm = 1'b0;
  logic        sink_calm = 1'b0;

  // keyword index doubles as the service code; index 0 is "all"
  function automatic string kw_text(input int k);
    case (k)
      int'(KW_ALL):        return "all";
      int'(SVC_SSH):       return "ssh";
      int'(SVC_NOAUTHSSH): return "no-auth-ssh";
      int'(SVC_FILES):     return "files";
      int'(SVC_EXEC):      return "exec";
      default:             return "exit-node";
    endcase
  endfunction

  task automatic clear_entry();
    ent_open   = 1'b0;
    blank_held = 1'b0;
    kw_live    = '1;
    body_len   = '0;
    on_upper   = 1'b0;
    lo_acc     = 0;
    hi_acc     = 0;
    lo_flt     = FLT_NONE;
    hi_flt     = FLT_NONE;
  endtask

  task automatic bump_len();
    if (body_len != LEN_SAT) body_len++;
  endtask

  // decimal accumulate into one bound; the first fault sticks
  task automatic take_digit(inout fault_t f, inout int unsigned acc,
                            input logic [7:0] c);
    int unsigned v;
    if (f != FLT_NONE) return;
    if (c < CH_ZERO || c > CH_NINE) begin
      f = FLT_INVALID;
      return;
    end
    v = acc * 10 + int'(c - CH_ZERO);
    if (v > MAX_PORT) f = FLT_OVER;
    else acc = v;
  endtask

  task automatic feed_char(input logic [7:0] c);
    if (on_upper) take_digit(hi_flt, hi_acc, c);
    else take_digit(lo_flt, lo_acc, c);
  endtask

  function automatic status_t bound_verdict(input fault_t f, input int unsigned v);
    if (f == FLT_INVALID) return ST_INVALID;
    if (f == FLT_OVER) return ST_RANGE;
    return (v == 0) ? ST_INVALID : ST_OK;
  endfunction

  // verdict on the entry closed by a comma or by the end word
  function automatic port_result_t judge_entry(input logic at_end);
    port_result_t r;
    int           hit;
    int           k;
    string        word;
    int unsigned  a;
    int unsigned  b;
    int unsigned  t;
    status_t      s;
    service_t     svc;
    hit = -1;
    for (k = 0; k < NUM_KW; k++) begin
      word = kw_text(k);
      if (hit < 0 && kw_live[k] && body_len == word.len()) hit = k;
    end
    a   = 0;
    b   = 0;
    s   = ST_OK;
    svc = SVC_NONE;
    if (body_len == 0) begin
      s = ST_INVALID;
    end else if (hit == int'(KW_ALL)) begin
      a = 1;
      b = 32'(MAX_PORT);
    end else if (hit > 0) begin
      s   = ST_UNSUPPORTED;
      svc = service_t'(hit);
    end else begin
      // lower bound is judged first
      s = bound_verdict(lo_flt, lo_acc);
      if (s == ST_OK && on_upper) s = bound_verdict(hi_flt, hi_acc);
      if (s == ST_OK) begin
        a = lo_acc;
        b = on_upper ? hi_acc : lo_acc;
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
      end
    end
    if (s != ST_OK) begin
      a = 0;
      b = 0;
    end
    r.rng  = (s == ST_OK);
    r.lo   = a[15:0];
    r.hi   = b[15:0];
    r.done = at_end || (s != ST_OK);
    r.st   = s;
    r.svc  = svc;
    return r;
  endfunction

  // advance the tracked state by one accepted word
  task automatic parse_spec_word(input cmd_t op, input logic [7:0] c);
    port_result_t r;
    int           k;
    string        word;
    if (op == CMD_END) begin
      // after an error the end word only rearms the parser
      if (!spec_dead) begin
        r = judge_entry(1'b1);
        spec_verdicts.push_back(r);
      end
      clear_entry();
      spec_dead = 1'b0;
    end else if (!spec_dead) begin
      if (c == CH_COMMA) begin
        r = judge_entry(1'b0);
        spec_verdicts.push_back(r);
        clear_entry();
        if (r.st != ST_OK) spec_dead = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if (ent_open) blank_held = 1'b1;
      end else begin
        ent_open = 1'b1;
        // a blank inside the body turns into a bad character at its place
        if (blank_held) begin
          feed_char(CH_SPACE);
          kw_live = '0;
          bump_len();
          blank_held = 1'b0;
        end
        for (k = 0; k < NUM_KW; k++) begin
          word = kw_text(k);
          if (kw_live[k] && (body_len >= word.len() || word[body_len] != c))
            kw_live[k] = 1'b0;
        end
        // only a dash after the first character splits the bounds
        if (c == CH_DASH && body_len >= 1 && !on_upper) on_upper = 1'b1;
        else feed_char(c);
        bump_len();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  task automatic push_word(input cmd_t op, input logic [7:0] c);
    spec_word_t w;
    w.op = op;
    w.c  = c;
    spec_stream.push_back(w);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_word(CMD_CHAR, s[i]);
  endtask

  task automatic push_blanks(input int n);
    int i;
    for (i = 0; i < n; i++) push_word(CMD_CHAR, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic push_end();
    // ch is a don't-care on the end word, so let it wander
    push_word(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned draw_port();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 10) return 32'(MAX_PORT);
    if (roll < 14) return $urandom_range(65536, 999999);
    if (roll < 16) return $urandom();   // long digit strings
    if (roll < 20) return 1;
    if (roll < 60) return $urandom_range(1, 1023);
    return $urandom_range(1, 65535);
  endfunction

  task automatic push_port(input int unsigned v);
    int i;
    int zeros;
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
    for (i = 0; i < zeros; i++) push_word(CMD_CHAR, CH_ZERO);
    push_text($sformatf("%0d", v));
  endtask

  task automatic push_mangled_keyword();
    string word;
    int    i;
    int    cut;
    int    pick;
    word = kw_text($urandom_range(0, NUM_KW - 1));
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      // truncated
      cut = $urandom_range(1, word.len() - 1);
      for (i = 0; i < cut; i++) push_word(CMD_CHAR, word[i]);
    end else if (pick == 1) begin
      // one letter too many
      push_text(word);
      push_word(CMD_CHAR, 8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      // one letter swapped
      cut = $urandom_range(0, word.len() - 1);
      for (i = 0; i < word.len(); i++)
        push_word(CMD_CHAR, (i == cut) ? 8'($urandom_range(8'h61, 8'h7A)) : word[i]);
    end
  endtask

  task automatic push_malformed();
    int i;
    int n;
    case ($urandom_range(0, 5))
      0: begin  // leading dash
        push_word(CMD_CHAR, CH_DASH);
        push_port(draw_port());
      end
      1: begin  // second dash
        push_port(draw_port());
        push_word(CMD_CHAR, CH_DASH);
        push_port(draw_port());
        push_word(CMD_CHAR, CH_DASH);
        push_port(draw_port());
      end
      2: begin  // blank inside the body
        push_port(draw_port());
        push_blanks($urandom_range(1, 2));
        push_port(draw_port());
      end
      3: begin  // stray byte between digits
        push_port(draw_port());
        push_word(CMD_CHAR, 8'($urandom_range(0, 255)));
        push_port(draw_port());
      end
      4: begin  // raw noise, commas included
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_word(CMD_CHAR, 8'($urandom_range(0, 255)));
      end
      default: begin  // empty upper bound
        push_port(draw_port());
        push_word(CMD_CHAR, CH_DASH);
      end
    endcase
  endtask

  task automatic push_entry();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    push_blanks($urandom_range(0, 2));
    if (kind < 35) begin
      push_port(draw_port());
    end else if (kind < 60) begin
      push_port(draw_port());
      push_word(CMD_CHAR, CH_DASH);
      push_port(draw_port());
    end else if (kind < 72) begin
      push_text(kw_text($urandom_range(0, NUM_KW - 1)));
    end else if (kind < 78) begin
      push_mangled_keyword();
    end else if (kind >= 82) begin
      push_malformed();
    end
    // 78..81 leave the entry empty
    push_blanks($urandom_range(0, 2));
  endtask

  task automatic push_spec();
    int i;
    int n;
    n = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      if (i != 0) push_word(CMD_CHAR, CH_COMMA);
      push_entry();
    end
    if (n == 0) push_blanks($urandom_range(0, 3));
    if ($urandom_range(0, 19) == 0) push_word(CMD_CHAR, CH_COMMA);
    push_end();
  endtask

  // pause length; calm stretches run with no pauses at all
  function automatic int unsigned pick_pause(input logic calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Result check against the oldest owed result
  // ---------------------------------------------------------------------
  task automatic check_result();
    port_result_t e;
    if (spec_verdicts.size() == 0) begin
      if (bad_words < REPORT_MAX)
        $display("cycle %0d: result word with none owed: %s",
                 cycles, $sformatf("rv=%0b lo=%0d hi=%0d done=%0b st=%0d sv=%0d",
                 range_valid, range_lo, range_hi, done_res, status, service));
      bad_words++;
    end else begin
      e = spec_verdicts.pop_front();
      if (range_valid !== e.rng || range_lo !== e.lo || range_hi !== e.hi ||
          done_res !== e.done || status !== e.st || service !== e.svc) begin
        if (bad_words < REPORT_MAX) begin
          $display("cycle %0d: expected rv=%0b lo=%0d hi=%0d done=%0b st=%0d sv=%0d",
                   cycles, e.rng, e.lo, e.hi, e.done, e.st, e.svc);
          $display("cycle %0d: got      rv=%0b lo=%0d hi=%0d done=%0b st=%0d sv=%0d",
                   cycles, range_valid, range_lo, range_hi, done_res, status, service);
        end
        bad_words++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: takes words off the stream, holds each until accepted
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
      clear_entry();
      spec_dead = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_spec_word(cmd_t'(cmd), ch);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (spec_stream.size() != 0) begin
          next_word = spec_stream.pop_front();
          in_valid <= 1'b1;
          cmd      <= next_word.op;
          ch       <= next_word.c;
          src_gap = pick_pause(src_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted result, stalls the output at random
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
      if (sink_gap != 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        sink_gap = pick_pause(sink_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // directed specs: empty spec; tab-led reversed full-width range closed
    // by a blank and a comma, then "all" at the end; one above the top port;
    // leading dash, with the character after the error swallowed
    push_word(CMD_END, 8'h00);
    push_text("\t65535-1 ,all");
    push_word(CMD_END, 8'hFF);
    push_text("65536");
    push_word(CMD_END, 8'h00);
    push_text("-7,x");
    push_word(CMD_END, 8'h00);

    // random specs, mostly well formed with random content
    while (spec_stream.size() < STREAM_WORDS) push_spec();
    words_total = spec_stream.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (words_taken != words_total) @(posedge clk);
    while (spec_verdicts.size() != 0) @(posedge clk);
    // let any stray late word show up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_words == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/plsp_pkg.sv
hdl/port_list_spec_parser.sv
tb/tb_port_list_spec_parser.sv
